[rtl/core/teq_pkg.sv]
// ---------------------------------------------------------------------------
// teq_pkg: shared types, constants and helpers
// Request and result payloads, command codes and tick arithmetic helpers for
// the timer event queue.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package teq_pkg;

  localparam int SLOT_COUNT    = 16;
  localparam int LOCAL_ID_BITS = 12;
  localparam int TICK_BITS     = 32;
  localparam int SLOT_BITS     = $clog2(SLOT_COUNT);
  localparam int MAX_RES       = 16;
  localparam int CNT_BITS      = $clog2(MAX_RES + 1);
  localparam int RES_BITS      = $clog2(MAX_RES);

  localparam logic [1:0] FN_POST     = 2'd0;
  localparam logic [1:0] FN_CANCEL   = 2'd1;
  localparam logic [1:0] FN_DISPATCH = 2'd2;
  localparam logic [1:0] FN_QUERY    = 2'd3;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_NOMEM    = 2'd1;
  localparam logic [1:0] ST_NOEVENT  = 2'd2;
  localparam logic [1:0] ST_INVALID  = 2'd3;

  localparam logic [3:0] CMD_NONE  = 4'd0;
  localparam logic [3:0] CMD_LOAD  = 4'd1;
  localparam logic [3:0] CMD_POST  = 4'd2;
  localparam logic [3:0] CMD_CHECK = 4'd3;
  localparam logic [3:0] CMD_DINIT = 4'd4;
  localparam logic [3:0] CMD_SEL   = 4'd5;
  localparam logic [3:0] CMD_PICK  = 4'd6;
  localparam logic [3:0] CMD_FIRE  = 4'd7;
  localparam logic [3:0] CMD_MINIT = 4'd8;
  localparam logic [3:0] CMD_MIN   = 4'd9;
  localparam logic [3:0] CMD_EMIT  = 4'd10;
  localparam logic [3:0] CMD_ENEXT = 4'd11;

  typedef logic [SLOT_BITS-1:0]            slot_t;
  typedef logic [TICK_BITS-1:0]            tick_t;
  typedef logic signed [TICK_BITS-1:0]     tdiff_t;
  typedef logic [LOCAL_ID_BITS-1:0]        local_t;
  typedef logic [CNT_BITS-1:0]             cnt_t;

  typedef struct packed {
    logic [1:0]         func;
    logic [31:0]        now;
    logic signed [31:0] delay;
    logic signed [31:0] period;
    logic [15:0]        event_id;
  } req_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [15:0] result_id;
    logic [30:0] time_left;
    logic        fired;
    logic        last;
    logic [30:0] next_delay;
    logic        queue_empty;
  } res_t;

  typedef struct packed {
    logic [3:0] op;
  } cmd_t;

  typedef struct packed {
    logic [1:0] func;
    logic       ptr_last;
    logic       found;
    logic       cnt_full;
    logic       out_take;
    logic       res_last;
  } stat_t;

  function automatic tdiff_t tick_diff(tick_t a, tick_t b);
    tick_t d;
    d = a - b;
    return tdiff_t'(d);
  endfunction

  function automatic logic [30:0] clamp31(tdiff_t d);
    logic [31:0] w;
    w = 32'(d);
    if (d < 0) return 31'd0;
    return w[30:0];
  endfunction

  function automatic local_t bump_local(local_t l);
    local_t v;
    v = l + local_t'(1);
    return (v == '0) ? local_t'(1) : v;
  endfunction

  function automatic logic [15:0] make_id(slot_t s, local_t l);
    logic [31:0] w;
    w = (32'(l) << SLOT_BITS) | 32'(s);
    return w[15:0];
  endfunction

endpackage

`default_nettype wire

[rtl/core/teq_ctrl.sv]
// ---------------------------------------------------------------------------
// teq_ctrl: sequencer
// Steps each request through its execute, selection scans, firing, deadline
// scan and result delivery by issuing commands to the datapath.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module teq_ctrl (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           req_valid,
  output logic                req_stall,
  input  teq_pkg::stat_t      stat,
  output teq_pkg::cmd_t       cmd
);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_EXEC  = 4'd1;
  localparam logic [3:0] S_SEL   = 4'd2;
  localparam logic [3:0] S_PICK  = 4'd3;
  localparam logic [3:0] S_FIRE  = 4'd4;
  localparam logic [3:0] S_FNEXT = 4'd5;
  localparam logic [3:0] S_MSCAN = 4'd6;
  localparam logic [3:0] S_EMIT  = 4'd7;
  localparam logic [3:0] S_WAIT  = 4'd8;

  logic [3:0] state;
  logic [3:0] state_next;

  assign req_stall = (state != S_IDLE);

  always_comb begin
    state_next = state;
    cmd.op     = teq_pkg::CMD_NONE;
    unique case (state)
      S_IDLE: begin
        if (req_valid) begin
          cmd.op     = teq_pkg::CMD_LOAD;
          state_next = S_EXEC;
        end
      end
      S_EXEC: begin
        unique case (stat.func)
          teq_pkg::FN_POST: begin
            cmd.op     = teq_pkg::CMD_POST;
            state_next = S_MSCAN;
          end
          teq_pkg::FN_DISPATCH: begin
            cmd.op     = teq_pkg::CMD_DINIT;
            state_next = S_SEL;
          end
          default: begin
            cmd.op     = teq_pkg::CMD_CHECK;
            state_next = S_MSCAN;
          end
        endcase
      end
      S_SEL: begin
        cmd.op = teq_pkg::CMD_SEL;
        if (stat.ptr_last) state_next = S_PICK;
      end
      S_PICK: begin
        if (stat.found) begin
          cmd.op     = teq_pkg::CMD_PICK;
          state_next = S_FIRE;
        end else begin
          cmd.op     = teq_pkg::CMD_MINIT;
          state_next = S_MSCAN;
        end
      end
      S_FIRE: begin
        cmd.op     = teq_pkg::CMD_FIRE;
        state_next = S_FNEXT;
      end
      S_FNEXT: begin
        if (stat.cnt_full) begin
          cmd.op     = teq_pkg::CMD_MINIT;
          state_next = S_MSCAN;
        end else begin
          state_next = S_SEL;
        end
      end
      S_MSCAN: begin
        cmd.op = teq_pkg::CMD_MIN;
        if (stat.ptr_last) state_next = S_EMIT;
      end
      S_EMIT: begin
        cmd.op     = teq_pkg::CMD_EMIT;
        state_next = S_WAIT;
      end
      S_WAIT: begin
        if (stat.out_take) begin
          if (stat.res_last) begin
            state_next = S_IDLE;
          end else begin
            cmd.op     = teq_pkg::CMD_ENEXT;
            state_next = S_EMIT;
          end
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

`default_nettype wire

[rtl/core/teq_datapath.sv]
// ---------------------------------------------------------------------------
// teq_datapath: slot storage and scan datapath
// Holds the event slots, the selection and deadline scan registers, the list
// of fired ids and the result register.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module teq_datapath (
  input  wire logic           clk,
  input  wire logic           rst,
  input  teq_pkg::req_t       req,
  input  teq_pkg::cmd_t       cmd,
  output teq_pkg::stat_t      stat,
  output logic                res_valid,
  input  wire logic           res_stall,
  output teq_pkg::res_t       res
);

  teq_pkg::tick_t  slot_target [teq_pkg::SLOT_COUNT];
  logic [31:0]     slot_period [teq_pkg::SLOT_COUNT];
  logic [15:0]     slot_order  [teq_pkg::SLOT_COUNT];
  teq_pkg::local_t slot_local_id [teq_pkg::SLOT_COUNT];
  logic [teq_pkg::SLOT_COUNT-1:0] slot_busy;
  logic [teq_pkg::SLOT_COUNT-1:0] taken;
  logic [15:0]     insert_counter;
  teq_pkg::tick_t  last_dispatch_tick;

  logic [1:0]         func;
  teq_pkg::tick_t     now;
  logic signed [31:0] delay;
  logic signed [31:0] period;
  logic [15:0]        eid;

  teq_pkg::slot_t  ptr;
  logic            found;
  teq_pkg::tdiff_t best_d;
  logic [15:0]     best_ord;
  teq_pkg::slot_t  best_slot;
  logic            any;
  teq_pkg::tdiff_t min_d;
  teq_pkg::cnt_t   cnt;
  teq_pkg::cnt_t   k;
  logic [15:0]     fire_list [teq_pkg::MAX_RES];
  logic [1:0]      r_status;
  logic [15:0]     r_id;
  logic [30:0]     r_tl;

  teq_pkg::slot_t  free_slot;
  logic            full;
  teq_pkg::slot_t  eid_slot;
  logic            eid_in_range;
  teq_pkg::slot_t  addr;
  teq_pkg::tick_t  rd_target;
  logic [31:0]     rd_period;
  logic [15:0]     rd_order;
  teq_pkg::local_t rd_local;
  logic            rd_busy;
  teq_pkg::tdiff_t rd_d;
  logic [15:0]     ord_diff;
  logic            cand;
  logic            better;
  logic [31:0]     dly;
  teq_pkg::tick_t  post_t;
  teq_pkg::tick_t  rearm_t;
  logic            id_match;
  logic            disp_list;
  logic            out_take;
  logic            is_last;

  always_comb begin
    free_slot = '0;
    full      = 1'b1;
    for (int i = teq_pkg::SLOT_COUNT - 1; i >= 0; i--) begin
      if (!slot_busy[i]) begin
        free_slot = teq_pkg::slot_t'(i);
        full      = 1'b0;
      end
    end
  end

  assign eid_slot     = eid[teq_pkg::SLOT_BITS-1:0];
  assign eid_in_range = (32'(eid_slot) < 32'(teq_pkg::SLOT_COUNT));

  always_comb begin
    priority case (cmd.op)
      teq_pkg::CMD_POST:  addr = free_slot;
      teq_pkg::CMD_CHECK: addr = eid_slot;
      default:            addr = ptr;
    endcase
  end

  assign rd_target = slot_target[addr];
  assign rd_period = slot_period[addr];
  assign rd_order  = slot_order[addr];
  assign rd_local  = slot_local_id[addr];
  assign rd_busy   = slot_busy[addr];
  assign rd_d      = teq_pkg::tick_diff(rd_target, now);

  assign ord_diff = rd_order - best_ord;
  assign cand     = rd_busy && !taken[addr] && (rd_d <= 0);
  assign better   = !found || (rd_d < best_d) || ((rd_d == best_d) && ord_diff[15]);

  assign dly     = delay[31] ? 32'd0 : 32'(delay);
  assign post_t  = now + dly[teq_pkg::TICK_BITS-1:0];
  assign rearm_t = rd_target + rd_period[teq_pkg::TICK_BITS-1:0];

  assign id_match = rd_busy && (32'(eid >> teq_pkg::SLOT_BITS) == 32'(rd_local));

  assign disp_list = (func == teq_pkg::FN_DISPATCH) && (cnt != '0);
  assign is_last   = disp_list ? (k == cnt - teq_pkg::cnt_t'(1)) : 1'b1;
  assign out_take  = res_valid && !res_stall;

  assign stat.func     = func;
  assign stat.ptr_last = (32'(ptr) == 32'(teq_pkg::SLOT_COUNT - 1));
  assign stat.found    = found;
  assign stat.cnt_full = (32'(cnt) == 32'(teq_pkg::MAX_RES));
  assign stat.out_take = out_take;
  assign stat.res_last = is_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      slot_busy          <= '0;
      insert_counter     <= '0;
      last_dispatch_tick <= '0;
      res_valid          <= 1'b0;
      for (int i = 0; i < teq_pkg::SLOT_COUNT; i++) begin
        slot_local_id[i] <= teq_pkg::local_t'(1);
      end
    end else begin
      if (out_take) res_valid <= 1'b0;
      unique case (cmd.op)
        teq_pkg::CMD_LOAD: begin
          func   <= req.func;
          now    <= req.now[teq_pkg::TICK_BITS-1:0];
          delay  <= req.delay;
          period <= req.period;
          eid    <= req.event_id;
        end
        teq_pkg::CMD_POST: begin
          ptr <= '0;
          any <= 1'b0;
          k   <= '0;
          cnt <= '0;
          r_tl <= '0;
          if (full) begin
            r_status <= teq_pkg::ST_NOMEM;
            r_id     <= '0;
          end else begin
            r_status            <= teq_pkg::ST_OK;
            r_id                <= teq_pkg::make_id(addr, rd_local);
            slot_period[addr]   <= period;
            slot_target[addr]   <= (teq_pkg::tick_diff(post_t, now) < 0) ? now : post_t;
            slot_order[addr]    <= insert_counter;
            insert_counter      <= insert_counter + 16'd1;
            slot_busy[addr]     <= 1'b1;
          end
        end
        teq_pkg::CMD_CHECK: begin
          ptr  <= '0;
          any  <= 1'b0;
          k    <= '0;
          cnt  <= '0;
          r_id <= '0;
          r_tl <= '0;
          if (!eid_in_range) begin
            r_status <= teq_pkg::ST_INVALID;
          end else if (!id_match) begin
            r_status <= teq_pkg::ST_NOEVENT;
          end else begin
            r_status <= teq_pkg::ST_OK;
            if (func == teq_pkg::FN_CANCEL) begin
              slot_busy[addr]     <= 1'b0;
              slot_local_id[addr] <= teq_pkg::bump_local(rd_local);
            end else begin
              r_tl <= teq_pkg::clamp31(rd_d);
            end
          end
        end
        teq_pkg::CMD_DINIT: begin
          if (teq_pkg::tick_diff(last_dispatch_tick, now) <= 0) last_dispatch_tick <= now;
          taken    <= '0;
          cnt      <= '0;
          k        <= '0;
          ptr      <= '0;
          found    <= 1'b0;
          r_status <= teq_pkg::ST_OK;
          r_id     <= '0;
          r_tl     <= '0;
        end
        teq_pkg::CMD_SEL: begin
          ptr <= ptr + teq_pkg::slot_t'(1);
          if (cand && better) begin
            found     <= 1'b1;
            best_d    <= rd_d;
            best_ord  <= rd_order;
            best_slot <= addr;
          end
        end
        teq_pkg::CMD_PICK: begin
          ptr <= best_slot;
        end
        teq_pkg::CMD_FIRE: begin
          fire_list[cnt[teq_pkg::RES_BITS-1:0]] <= teq_pkg::make_id(addr, rd_local);
          cnt         <= cnt + teq_pkg::cnt_t'(1);
          taken[addr] <= 1'b1;
          ptr         <= '0;
          found       <= 1'b0;
          if (!rd_period[31]) begin
            slot_target[addr] <= (teq_pkg::tick_diff(rearm_t, now) < 0) ? now : rearm_t;
            slot_order[addr]  <= insert_counter;
            insert_counter    <= insert_counter + 16'd1;
          end else begin
            slot_busy[addr]     <= 1'b0;
            slot_local_id[addr] <= teq_pkg::bump_local(rd_local);
          end
        end
        teq_pkg::CMD_MINIT: begin
          ptr <= '0;
          any <= 1'b0;
        end
        teq_pkg::CMD_MIN: begin
          ptr <= ptr + teq_pkg::slot_t'(1);
          if (rd_busy && (!any || rd_d < min_d)) begin
            min_d <= rd_d;
            any   <= 1'b1;
          end
        end
        teq_pkg::CMD_EMIT: begin
          res_valid       <= 1'b1;
          res.last        <= is_last;
          res.next_delay  <= any ? teq_pkg::clamp31(min_d) : 31'd0;
          res.queue_empty <= !any;
          if (disp_list) begin
            res.status    <= teq_pkg::ST_OK;
            res.result_id <= fire_list[k[teq_pkg::RES_BITS-1:0]];
            res.time_left <= '0;
            res.fired     <= 1'b1;
          end else begin
            res.status    <= r_status;
            res.result_id <= r_id;
            res.time_left <= r_tl;
            res.fired     <= 1'b0;
          end
        end
        teq_pkg::CMD_ENEXT: begin
          k <= k + teq_pkg::cnt_t'(1);
        end
        default: begin
        end
      endcase
    end
  end

endmodule

`default_nettype wire

[rtl/core/timer_event_queue_top.sv]
// ---------------------------------------------------------------------------
// timer_event_queue_top: timer event queue
// Fixed set of timed event slots with post, cancel, dispatch and query.
// ---------------------------------------------------------------------------
// Post, cancel and query run a deadline scan over all slots before the result.
// Dispatch repeats a selection scan and a firing per event until none is due
// or MAX_RES events have fired, then runs the deadline scan.
// One request at a time; each result is held until taken before the next one.
// Synchronous reset frees all slots and sets every local id to one.
`timescale 1ns / 1ps
`default_nettype none

module timer_event_queue_top (
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      req_valid,
  output logic           req_stall,
  input  teq_pkg::req_t  req,
  output logic           res_valid,
  input  wire logic      res_stall,
  output teq_pkg::res_t  res
);

  teq_pkg::cmd_t  cmd;
  teq_pkg::stat_t stat;

  teq_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .stat      (stat),
    .cmd       (cmd)
  );

  teq_datapath u_dp (
    .clk       (clk),
    .rst       (rst),
    .req       (req),
    .cmd       (cmd),
    .stat      (stat),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .res       (res)
  );

  a_busy_after_req: assert property (@(posedge clk) disable iff (rst)
    (req_valid && !req_stall) |=> req_stall)
    else $error("request accepted while not busy afterwards");

  a_no_req_with_res: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> req_stall)
    else $error("request channel open while a result is pending");

  a_last_drains: assert property (@(posedge clk) disable iff (rst)
    (res_valid && !res_stall && res.last) |=> !res_valid)
    else $error("result after the last one of a request");

endmodule

`default_nettype wire
